FILE: src/ckms_pkg.sv
// Shared constants and types for the capacitive key matrix scanner.
`timescale 1ns / 1ps
`default_nettype none
package ckms_pkg;

  localparam int ROW_COUNT = 8;
  localparam int COL_COUNT = 8;
  localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

  localparam int IDLE_W = 20;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = IDLE_W'(10000);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COL_COUNT - 1);

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_IDLE_LIMIT = '0;

  typedef logic [COL_COUNT-1:0] row_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

endpackage
`default_nettype wire

FILE: src/capacitive_key_matrix_scan_top.sv
// Capacitive key matrix scanner: key maps, scan position, idle timer and power control.
`timescale 1ns / 1ps
`default_nettype none
// Scans an 8x8 capacitive key matrix one key per item in row-major order and
// returns one result item for every input item. An item is taken whenever no result is
// held or out_tready is high; all work is a single pass of logic from the accepted item
// and the stored state into the result register, so the result follows in the next
// cycle and the rate is one item per clock while out_tready is high. The two key maps
// are flip-flops with a bank pointer; the exchange at the start of a scan only flips
// the pointer. The idle limit register sits at byte address 0 of the configuration
// port; the user must write it only while the block is idle; the block does not enforce this.
module capacitive_key_matrix_scan_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // APB-style configuration port
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [ckms_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready,
  // input items
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // sense_level, sample_late, read_index[2:0], host_suspended, pad
  input  wire logic [7:0]                  in_tdata,
  input  wire logic [1:0]                  in_tuser,  // action
  // result items
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // select_row[2:0], select_col[2:0], prev_drive, row_bits[7:0],
  // sensor_power, power_down_request, pad
  output logic [23:0]                      out_tdata,
  output logic                             out_tlast  // scan_complete
);
  import ckms_pkg::*;

  // state
  row_t               bank_r [2][ROW_COUNT];
  logic               cur_b_r;
  logic [ROW_W-1:0]   row_pos_r;
  logic [COL_W-1:0]   col_pos_r;
  logic [IDLE_W-1:0]  idle_r;
  logic               power_r;
  logic [IDLE_W-1:0]  idle_limit_r;

  // output register
  logic               out_valid_r;
  logic [23:0]        out_data_r;
  logic               out_last_r;

  // next values
  row_t               bank_nxt [2][ROW_COUNT];
  logic               cur_b_nxt;
  logic [ROW_W-1:0]   row_pos_nxt;
  logic [COL_W-1:0]   col_pos_nxt;
  logic [IDLE_W-1:0]  idle_nxt;
  logic               power_nxt;
  logic [23:0]        out_data_nxt;
  logic               out_last_nxt;

  // item fields
  action_t            action;
  logic               sense_level;
  logic               sample_late;
  logic [2:0]         read_index;
  logic               host_suspended;

  logic               in_acc;
  logic               cfg_wr;

  // combinational temporaries
  logic               first_key;
  logic               cb;
  row_t               mask;
  row_t               new_row;
  row_t               prv_row;
  row_t               next_row;
  row_t               read_row;
  logic [7:0]         row_bits;
  logic               pd_req;
  logic               prev_drive;

  assign action         = action_t'(in_tuser);
  assign sense_level    = in_tdata[0];
  assign sample_late    = in_tdata[1];
  assign read_index     = in_tdata[4:2];
  assign host_suspended = in_tdata[5];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_IDLE_LIMIT[CFG_AW-1:2]) ?
                      32'(idle_limit_r) : 32'd0;

  always_comb begin
    bank_nxt     = bank_r;
    cur_b_nxt    = cur_b_r;
    row_pos_nxt  = row_pos_r;
    col_pos_nxt  = col_pos_r;
    idle_nxt     = idle_r;
    power_nxt    = power_r;
    first_key    = (row_pos_r == '0) && (col_pos_r == '0);
    cb           = first_key ? !cur_b_r : cur_b_r;
    mask         = row_t'(1) << col_pos_r;
    prv_row      = bank_r[!cb][row_pos_r];
    new_row      = sense_level ? (bank_r[cb][row_pos_r] & ~mask)
                               : (bank_r[cb][row_pos_r] | mask);
    read_row     = bank_r[cur_b_r][ROW_W'(read_index)];
    row_bits     = 8'd0;
    pd_req       = 1'b0;
    out_last_nxt = 1'b0;

    case (action)
      ACT_SAMPLE: begin
        // the first key of a scan swaps the maps and powers the sensor
        if (first_key) begin
          cur_b_nxt = !cur_b_r;
          power_nxt = 1'b1;
        end
        if (sample_late) begin
          new_row = prv_row;
        end
        bank_nxt[cb][row_pos_r] = new_row;
        col_pos_nxt = col_pos_r + COL_W'(1);
        if (col_pos_r == COL_LAST) begin
          col_pos_nxt = '0;
          if (new_row != prv_row) begin
            idle_nxt = '0;
          end
          row_pos_nxt = row_pos_r + ROW_W'(1);
          if (row_pos_r == ROW_LAST) begin
            row_pos_nxt  = '0;
            out_last_nxt = 1'b1;
            if (power_nxt && host_suspended && (idle_nxt > idle_limit_r)) begin
              power_nxt = 1'b0;
              pd_req    = 1'b1;
            end
          end
        end
      end
      ACT_TICK: begin
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + IDLE_W'(1);
        end
      end
      ACT_READ: begin
        if (32'(read_index) < ROW_COUNT) begin
          row_bits = 8'(read_row);
        end
      end
      default: begin
      end
    endcase

    // hysteresis bit of the next key; a new scan reads the map that becomes previous
    if ((row_pos_nxt == '0) && (col_pos_nxt == '0)) begin
      next_row = bank_nxt[cur_b_nxt][row_pos_nxt];
    end else begin
      next_row = bank_nxt[!cur_b_nxt][row_pos_nxt];
    end
    prev_drive = next_row[col_pos_nxt];

    out_data_nxt = {7'd0, pd_req, power_nxt, row_bits, prev_drive,
                    3'(col_pos_nxt), 3'(row_pos_nxt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < ROW_COUNT; r++) begin
          bank_r[b][r] <= '0;
        end
      end
      cur_b_r      <= 1'b0;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      idle_r       <= '0;
      power_r      <= 1'b0;
      idle_limit_r <= IDLE_LIMIT_RESET;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_IDLE_LIMIT[CFG_AW-1:2])) begin
        idle_limit_r <= cfg_pwdata[IDLE_W-1:0];
      end
      if (in_acc) begin
        bank_r      <= bank_nxt;
        cur_b_r     <= cur_b_nxt;
        row_pos_r   <= row_pos_nxt;
        col_pos_r   <= col_pos_nxt;
        idle_r      <= idle_nxt;
        power_r     <= power_nxt;
        out_valid_r <= 1'b1;
        out_last_r  <= out_last_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  a_pd_at_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[16] |-> out_last_r && !out_data_r[15])
    else $error("power down outside scan end");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_pos_r) < ROW_COUNT) && (32'(col_pos_r) < COL_COUNT))
    else $error("scan position out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_idle_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (idle_r >= $past(idle_r)) || (idle_r == '0))
    else $error("idle counter moved backward");

  a_power_on_first_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (action == ACT_SAMPLE) && first_key && !out_last_nxt |=> power_r)
    else $error("first key did not power the sensor");
`endif

endmodule
`default_nettype wire
